// File: hw/rtl/rcf_pkg.sv
// shared types and constants of the rgb 5x5 convolution filter
`timescale 1ns / 1ps
package rcf_pkg;

    localparam int SUM_W      = 21;   // 25 taps of 255 * 255 fit in 21 bits
    localparam int COEFF_W    = 40;
    localparam int COEFF_ROWS = 5;
    localparam int MAX_HEIGHT = 4096;
    localparam int ROW_W      = 12;
    localparam int HDIM_W     = 13;
    localparam int FW_W       = 11;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEFF_ROW0   = 3'd0,
        REG_COEFF_ROW1   = 3'd1,
        REG_COEFF_ROW2   = 3'd2,
        REG_COEFF_ROW3   = 3'd3,
        REG_COEFF_ROW4   = 3'd4,
        REG_DIVISOR      = 3'd5,
        REG_FRAME_WIDTH  = 3'd6,
        REG_FRAME_HEIGHT = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ACC,
        ST_FLUSH,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_end;
    } pix_out_t;

    typedef logic [SUM_W-1:0] sum_t;

    typedef struct packed {
        logic            valid;
        logic [7:0]      div;
        sum_t [2:0]      dvd;
        sum_t [2:0]      quo;
        logic [2:0][7:0] rem;
    } div_stage_t;

endpackage

// File: hw/rtl/rcf_div_cell.sv
// one restoring division cell: settles one quotient bit for all three channels
`timescale 1ns / 1ps
module rcf_div_cell #(
    parameter int BIT = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  rcf_pkg::div_stage_t stage_in,
    output rcf_pkg::div_stage_t stage_out
);
    import rcf_pkg::*;

    div_stage_t stage_reg;
    div_stage_t stage_next;
    logic [8:0] trial [3];

    always_comb begin
        stage_next = stage_in;
        for (int c = 0; c < 3; c++) begin
            trial[c] = {stage_in.rem[c], stage_in.dvd[c][BIT]};
            if (trial[c] >= {1'b0, stage_in.div}) begin
                stage_next.rem[c]      = 8'(trial[c] - {1'b0, stage_in.div});
                stage_next.quo[c][BIT] = 1'b1;
            end else begin
                stage_next.rem[c] = trial[c][7:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

// File: hw/rtl/rcf_divider.sv
// chain of division cells, one quotient bit per cell, msb first
`timescale 1ns / 1ps
module rcf_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  rcf_pkg::div_stage_t div_in,
    output rcf_pkg::div_stage_t div_out
);
    import rcf_pkg::*;

    div_stage_t link [SUM_W+1];

    assign link[0] = div_in;

    for (genvar i = 0; i < SUM_W; i++) begin : g_cell
        rcf_div_cell #(
            .BIT(SUM_W - 1 - i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .stage_in (link[i]),
            .stage_out(link[i+1])
        );
    end

    assign div_out = link[SUM_W];

endmodule

// File: hw/rtl/rgb_conv5x5_filter.sv
// top level of the rgb 5x5 convolution filter
//
//  channel  | handshake             | content
//  ---------+-----------------------+---------------------------------------
//  s_       | s_valid / s_ready     | pix_in_t: pixel or drain tick
//  m_       | m_valid / m_ready     | pix_out_t: filtered pixel, frame_end
//  cfg_     | cfg_valid / cfg_ready | register index and write data
//
// one word at a time: s_ready is high only in the idle state. a word that releases
// an output goes through the tap walk over the line store read port, the multiply
// pipe and the 21-cell divider chain first; otherwise it returns to idle after the check.
// reset is synchronous; the line store is not cleared, only rows already
// received are ever read. a stalled m_ side holds the block in its output state.
`timescale 1ns / 1ps
module rgb_conv5x5_filter #(
    parameter int MAX_WIDTH     = 1024,
    parameter int KERNEL_RADIUS = 2
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  rcf_pkg::pix_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output rcf_pkg::pix_out_t                   m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rcf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rcf_pkg::COEFF_W-1:0]         cfg_data
);
    import rcf_pkg::*;

    localparam int K      = 2 * KERNEL_RADIUS + 1;
    localparam int RING   = 2 * KERNEL_RADIUS + 2;
    localparam int DEPTH  = RING * MAX_WIDTH;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int DIM_W  = $clog2(MAX_WIDTH + 1);
    localparam int SLOT_W = $clog2(RING);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int KW     = $clog2(K);
    localparam int XW     = DIM_W + 2;
    localparam int YW     = HDIM_W + 2;

    // configuration
    logic [COEFF_W-1:0] coeff_reg [COEFF_ROWS];
    logic [7:0]         divisor_reg;
    logic [FW_W-1:0]    fw_reg;
    logic [HDIM_W-1:0]  fh_reg;

    state_t state_reg, state_next;

    logic [COL_W-1:0]  in_col_reg, out_col_reg;
    logic [ROW_W-1:0]  in_row_reg, out_row_reg;
    logic [SLOT_W-1:0] in_slot_reg, out_slot_reg, tap_slot_reg;
    logic              frame_rx_reg;
    logic [DIM_W-1:0]  cur_w_reg;
    logic [HDIM_W-1:0] cur_h_reg;

    logic [KW-1:0]     ty_reg, tx_reg;
    logic [YW-1:0]     tap_y_reg;
    logic [XW-1:0]     tap_x_reg;

    logic              v1_reg, in1_reg, v2_reg;
    logic [7:0]        w1_reg;
    logic [23:0]       mem_q_reg;
    logic [15:0]       prod_reg [3];
    sum_t              acc_reg [3];
    logic [7:0]        res_reg [3];

    logic              m_valid_reg;
    pix_out_t          m_data_reg;

    logic [23:0]       line_mem [DEPTH];

    logic              s_accept, pix_wr, first_px, in_col_last, in_row_last;
    logic [DIM_W-1:0]  fw_clamp, eff_w;
    logic [HDIM_W-1:0] fh_clamp, eff_h;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [HDIM_W:0]   ry_w, ry;
    logic [DIM_W:0]    cx_w, cx;
    logic              out_ready_c, out_free, inframe, last_tap, launch;
    logic [7:0]        weight;
    logic [SLOT_W:0]   start_slot_w;
    logic [SLOT_W-1:0] start_slot;
    logic              out_col_last, out_row_last;
    div_stage_t        div_in, div_out;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign pix_wr    = s_accept && !s_data.kind && !frame_rx_reg;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_reg[0] <= COEFF_W'(64'h01_0000_0001);
            coeff_reg[1] <= '0;
            coeff_reg[2] <= '0;
            coeff_reg[3] <= '0;
            coeff_reg[4] <= COEFF_W'(64'h01_0000_0001);
            divisor_reg  <= 8'd4;
            fw_reg       <= FW_W'(640);
            fh_reg       <= HDIM_W'(480);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_COEFF_ROW0:   coeff_reg[0] <= cfg_data;
                REG_COEFF_ROW1:   coeff_reg[1] <= cfg_data;
                REG_COEFF_ROW2:   coeff_reg[2] <= cfg_data;
                REG_COEFF_ROW3:   coeff_reg[3] <= cfg_data;
                REG_COEFF_ROW4:   coeff_reg[4] <= cfg_data;
                REG_DIVISOR:      divisor_reg  <= cfg_data[7:0];
                REG_FRAME_WIDTH:  fw_reg       <= cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: fh_reg       <= cfg_data[HDIM_W-1:0];
                default:          divisor_reg  <= divisor_reg;
            endcase
        end
    end

    // frame size is taken when the first pixel of a frame comes in
    always_comb begin
        if (fw_reg == '0) begin
            fw_clamp = DIM_W'(1);
        end else if (32'(fw_reg) > 32'(MAX_WIDTH)) begin
            fw_clamp = DIM_W'(MAX_WIDTH);
        end else begin
            fw_clamp = DIM_W'(fw_reg);
        end
        if (fh_reg == '0) begin
            fh_clamp = HDIM_W'(1);
        end else if (32'(fh_reg) > 32'(MAX_HEIGHT)) begin
            fh_clamp = HDIM_W'(MAX_HEIGHT);
        end else begin
            fh_clamp = fh_reg;
        end
    end

    assign first_px    = (in_row_reg == '0) && (in_col_reg == '0);
    assign eff_w       = first_px ? fw_clamp : cur_w_reg;
    assign eff_h       = first_px ? fh_clamp : cur_h_reg;
    assign in_col_last = (DIM_W'(in_col_reg) + DIM_W'(1)) >= eff_w;
    assign in_row_last = (HDIM_W'(in_row_reg) + HDIM_W'(1)) >= eff_h;

    assign wr_addr = ADDR_W'(in_slot_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col_reg);
    assign rd_addr = ADDR_W'(tap_slot_reg) * ADDR_W'(MAX_WIDTH)
                   + ADDR_W'(tap_x_reg[COL_W-1:0]);

    // has the lower-right corner of the next output's window arrived
    always_comb begin
        ry_w = (HDIM_W+1)'(out_row_reg) + (HDIM_W+1)'(KERNEL_RADIUS);
        ry   = (ry_w > (HDIM_W+1)'(cur_h_reg - HDIM_W'(1)))
             ? (HDIM_W+1)'(cur_h_reg - HDIM_W'(1)) : ry_w;
        cx_w = (DIM_W+1)'(out_col_reg) + (DIM_W+1)'(KERNEL_RADIUS);
        cx   = (cx_w > (DIM_W+1)'(cur_w_reg - DIM_W'(1)))
             ? (DIM_W+1)'(cur_w_reg - DIM_W'(1)) : cx_w;
        out_ready_c = frame_rx_reg
                   || ((HDIM_W+1)'(in_row_reg) > ry)
                   || (((HDIM_W+1)'(in_row_reg) == ry) && ((DIM_W+1)'(in_col_reg) > cx));
    end

    assign start_slot_w = (SLOT_W+1)'(out_slot_reg) + (SLOT_W+1)'(RING - KERNEL_RADIUS);
    assign start_slot   = (start_slot_w >= (SLOT_W+1)'(RING))
                        ? SLOT_W'(start_slot_w - (SLOT_W+1)'(RING)) : SLOT_W'(start_slot_w);

    assign inframe = !tap_y_reg[YW-1] && (tap_y_reg < YW'(cur_h_reg))
                  && !tap_x_reg[XW-1] && (tap_x_reg < XW'(cur_w_reg));
    assign last_tap = (ty_reg == KW'(K - 1)) && (tx_reg == KW'(K - 1));

    // taps beyond the five coefficient rows and columns weigh nothing
    always_comb begin
        weight = 8'd0;
        if (32'(ty_reg) < COEFF_ROWS && 32'(tx_reg) < COEFF_ROWS) begin
            weight = coeff_reg[3'(ty_reg)][8 * 3'(tx_reg) +: 8];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_accept) state_next = ST_CHECK;
            ST_CHECK: state_next = out_ready_c ? ST_ACC : ST_IDLE;
            ST_ACC:   if (last_tap) state_next = ST_FLUSH;
            ST_FLUSH: if (!v1_reg && !v2_reg) state_next = ST_DIV;
            ST_DIV:   if (div_out.valid) state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    assign launch = (state_reg == ST_FLUSH) && !v1_reg && !v2_reg;

    always_comb begin
        div_in.valid = launch;
        div_in.div   = (divisor_reg == 8'd0) ? 8'd1 : divisor_reg;
        for (int c = 0; c < 3; c++) begin
            div_in.dvd[c] = acc_reg[c];
            div_in.quo[c] = '0;
            div_in.rem[c] = '0;
        end
    end

    rcf_divider u_divider (
        .aclk   (aclk),
        .aresetn(aresetn),
        .div_in (div_in),
        .div_out(div_out)
    );

    assign out_col_last = (DIM_W'(out_col_reg) + DIM_W'(1)) >= cur_w_reg;
    assign out_row_last = (HDIM_W'(out_row_reg) + HDIM_W'(1)) >= cur_h_reg;

    always_ff @(posedge aclk) begin
        if (pix_wr) begin
            line_mem[wr_addr] <= {s_data.pixel_red, s_data.pixel_green, s_data.pixel_blue};
        end
        mem_q_reg <= line_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            frame_rx_reg <= 1'b0;
            cur_w_reg    <= DIM_W'(640);
            cur_h_reg    <= HDIM_W'(480);
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (pix_wr) begin
                if (first_px) begin
                    cur_w_reg <= fw_clamp;
                    cur_h_reg <= fh_clamp;
                end
                if (in_col_last) begin
                    in_col_reg <= '0;
                    if (in_row_last) begin
                        in_row_reg   <= '0;
                        in_slot_reg  <= '0;
                        frame_rx_reg <= 1'b1;
                    end else begin
                        in_row_reg  <= in_row_reg + ROW_W'(1);
                        in_slot_reg <= (in_slot_reg == SLOT_W'(RING - 1))
                                     ? '0 : in_slot_reg + SLOT_W'(1);
                    end
                end else begin
                    in_col_reg <= in_col_reg + COL_W'(1);
                end
            end

            v1_reg <= (state_reg == ST_ACC);
            v2_reg <= v1_reg;

            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_OUT && out_free) begin
                if (out_col_last) begin
                    out_col_reg <= '0;
                    if (out_row_last) begin
                        out_row_reg  <= '0;
                        out_slot_reg <= '0;
                        frame_rx_reg <= 1'b0;
                    end else begin
                        out_row_reg  <= out_row_reg + ROW_W'(1);
                        out_slot_reg <= (out_slot_reg == SLOT_W'(RING - 1))
                                      ? '0 : out_slot_reg + SLOT_W'(1);
                    end
                end else begin
                    out_col_reg <= out_col_reg + COL_W'(1);
                end
            end
        end
    end

    // tap walk, multiply pipe, accumulators and result payload
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CHECK) begin
            ty_reg       <= '0;
            tx_reg       <= '0;
            tap_y_reg    <= YW'(out_row_reg) - YW'(KERNEL_RADIUS);
            tap_x_reg    <= XW'(out_col_reg) - XW'(KERNEL_RADIUS);
            tap_slot_reg <= start_slot;
            for (int c = 0; c < 3; c++) begin
                acc_reg[c] <= '0;
            end
        end else begin
            if (state_reg == ST_ACC) begin
                if (tx_reg == KW'(K - 1)) begin
                    tx_reg       <= '0;
                    tap_x_reg    <= XW'(out_col_reg) - XW'(KERNEL_RADIUS);
                    ty_reg       <= ty_reg + KW'(1);
                    tap_y_reg    <= tap_y_reg + YW'(1);
                    tap_slot_reg <= (tap_slot_reg == SLOT_W'(RING - 1))
                                  ? '0 : tap_slot_reg + SLOT_W'(1);
                end else begin
                    tx_reg    <= tx_reg + KW'(1);
                    tap_x_reg <= tap_x_reg + XW'(1);
                end
            end
            if (v2_reg) begin
                for (int c = 0; c < 3; c++) begin
                    acc_reg[c] <= acc_reg[c] + SUM_W'(prod_reg[c]);
                end
            end
        end

        in1_reg <= inframe;
        w1_reg  <= weight;
        for (int c = 0; c < 3; c++) begin
            prod_reg[c] <= in1_reg ? mem_q_reg[16 - 8 * c +: 8] * w1_reg : 16'd0;
        end

        if (state_reg == ST_DIV && div_out.valid) begin
            for (int c = 0; c < 3; c++) begin
                res_reg[c] <= (div_out.quo[c] > SUM_W'(255)) ? 8'd255 : div_out.quo[c][7:0];
            end
        end

        if (state_reg == ST_OUT && out_free) begin
            m_data_reg.out_red   <= res_reg[0];
            m_data_reg.out_green <= res_reg[1];
            m_data_reg.out_blue  <= res_reg[2];
            m_data_reg.frame_end <= out_col_last && out_row_last;
        end
    end

endmodule
